[sv/urs_pkg.sv]
// Shared widths, request and status codes, and controller types for the undo/redo stack pair.
package urs_pkg;

	// Default sizes
	localparam int MAIN_DEPTH_DEF    = 16;
	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int ITEM_BITS_DEF     = 16;

	// Field widths on the ports
	localparam int REQ_W     = 2;
	localparam int ID_W      = 16;
	localparam int STATUS_W  = 2;
	localparam int SCNT_W    = 5;
	localparam int HCNT_W    = 4;
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_UNDO = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REDO = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MAIN_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MAIN_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_HIST_EMPTY = 2'd3;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

[sv/urs_ctrl.sv]
// Controller state machine: accept a request, then execute it once the result register is free.
module urs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  urs_pkg::sts_t sts,
	output urs_pkg::cmd_t cmd
);
	import urs_pkg::*;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!sts.out_busy) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/urs_datapath.sv]
// Datapath: both stores, stack and ring counters, request decode and the result register.
module urs_datapath #(
	parameter int MAIN_DEPTH    = urs_pkg::MAIN_DEPTH_DEF,
	parameter int HISTORY_DEPTH = urs_pkg::HISTORY_DEPTH_DEF,
	parameter int ITEM_BITS     = urs_pkg::ITEM_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  urs_pkg::cmd_t                cmd,
	output urs_pkg::sts_t                sts,
	input  logic [urs_pkg::REQ_W-1:0]    req_type,
	input  logic [urs_pkg::ID_W-1:0]     item_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [urs_pkg::ID_W-1:0]     item_out,
	output logic [urs_pkg::STATUS_W-1:0] status,
	output logic [urs_pkg::SCNT_W-1:0]   stack_count,
	output logic [urs_pkg::HCNT_W-1:0]   history_count
);
	import urs_pkg::*;

	localparam int MA = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
	localparam int MC = $clog2(MAIN_DEPTH + 1);
	localparam int HA = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HC = $clog2(HISTORY_DEPTH + 1);
	localparam int HS = HC + 1;

	// Stores
	logic [ITEM_BITS-1:0] main_mem [MAIN_DEPTH];
	logic [ITEM_BITS-1:0] hist_mem [HISTORY_DEPTH];

	// Control state
	logic [MC-1:0] main_top_q;
	logic [HA-1:0] hist_base_q;
	logic [HC-1:0] hist_fill_q;
	logic          out_valid_q;

	// Request and read data
	logic [REQ_W-1:0]     req_q;
	logic [ITEM_BITS-1:0] id_q;
	logic [ITEM_BITS-1:0] main_rd_q;
	logic [ITEM_BITS-1:0] hist_rd_q;

	// Result register
	logic [ID_W-1:0]     item_out_q;
	logic [STATUS_W-1:0] status_q;

	// Next values
	logic [MC-1:0]        main_top_d;
	logic [HA-1:0]        hist_base_d;
	logic [HC-1:0]        hist_fill_d;
	logic [ITEM_BITS-1:0] moved;
	logic [STATUS_W-1:0]  status_d;
	logic                 main_we;
	logic [ITEM_BITS-1:0] main_wdata;
	logic                 hist_we;
	logic [HA-1:0]        hist_waddr;
	logic [MA-1:0]        main_raddr;
	logic [HA-1:0]        hist_raddr;
	logic                 main_full;
	logic                 hist_full;

	// Fold a ring sum below twice the depth back into a slot
	function automatic logic [HA-1:0] ring_wrap(input logic [HS-1:0] s);
		logic [HS-1:0] r;
		r = (s >= HS'(HISTORY_DEPTH)) ? s - HS'(HISTORY_DEPTH) : s;
		return r[HA-1:0];
	endfunction

	assign main_full  = (main_top_q >= MC'(MAIN_DEPTH));
	assign hist_full  = (hist_fill_q >= HC'(HISTORY_DEPTH));
	assign main_raddr = MA'(main_top_q - MC'(1));
	assign hist_raddr = ring_wrap(HS'(hist_base_q) + HS'(hist_fill_q) - HS'(1));

	// Decode the held request against the counters
	always_comb begin
		main_top_d  = main_top_q;
		hist_base_d = hist_base_q;
		hist_fill_d = hist_fill_q;
		moved       = '0;
		status_d    = ST_OK;
		main_we     = 1'b0;
		main_wdata  = id_q;
		hist_we     = 1'b0;
		hist_waddr  = ring_wrap(HS'(hist_base_q) + HS'(hist_fill_q));
		case (req_q)
			REQ_PUSH: begin
				if (main_full) begin
					status_d = ST_MAIN_FULL;
				end else begin
					main_we    = 1'b1;
					main_top_d = main_top_q + MC'(1);
				end
			end
			REQ_UNDO: begin
				if (main_top_q == '0) begin
					status_d = ST_MAIN_EMPTY;
				end else begin
					moved      = main_rd_q;
					main_top_d = main_top_q - MC'(1);
					hist_we    = 1'b1;
					if (hist_full) begin
						// overwrite the oldest slot, it becomes the newest
						hist_waddr  = hist_base_q;
						hist_base_d = ring_wrap(HS'(hist_base_q) + HS'(1));
					end else begin
						hist_fill_d = hist_fill_q + HC'(1);
					end
				end
			end
			REQ_REDO: begin
				if (hist_fill_q == '0) begin
					status_d = ST_HIST_EMPTY;
				end else if (main_full) begin
					status_d = ST_MAIN_FULL;
				end else begin
					moved       = hist_rd_q;
					main_we     = 1'b1;
					main_wdata  = hist_rd_q;
					main_top_d  = main_top_q + MC'(1);
					hist_fill_d = hist_fill_q - HC'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Stores: write on execute, read the tops every cycle
	always_ff @(posedge clk) begin
		if (cmd.exec && main_we) begin
			main_mem[main_top_q[MA-1:0]] <= main_wdata;
		end
		if (cmd.exec && hist_we) begin
			hist_mem[hist_waddr] <= moved;
		end
		main_rd_q <= main_mem[main_raddr];
		hist_rd_q <= hist_mem[hist_raddr];
	end

	// Hold the accepted request and the result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			id_q  <= ITEM_BITS'(item_id);
		end
		if (cmd.exec) begin
			item_out_q <= ID_W'(moved);
			status_q   <= status_d;
		end
	end

	// Advance counters and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_top_q  <= '0;
			hist_base_q <= '0;
			hist_fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				main_top_q  <= main_top_d;
				hist_base_q <= hist_base_d;
				hist_fill_q <= hist_fill_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign item_out      = item_out_q;
	assign status        = status_q;
	assign stack_count   = SCNT_W'(main_top_q);
	assign history_count = HCNT_W'(hist_fill_q);

endmodule

[sv/undo_redo_stack_pair.sv]
// Top level of the undo/redo stack pair: controller plus datapath on two item streams.
//
//  channel | direction | tdata (low bit up)                                | tuser
//  s_      | in        | item_id[15:0]                                     | req_type[1:0]
//  m_      | out       | item_out[15:0] status[17:16] stack_count[22:18]   | -
//          |           | history_count[26:23], zero pad to 32              |
//
// Each item is accepted in S_IDLE, where both store tops are also read, and then
// executed in S_EXEC, which updates the stores and counters and loads the result register.
// A new item is accepted while the previous result waits on m_; execution then
// holds until that result is taken, so a stalled m_ side blocks after one item.
// Reset clears the counters and the state; store contents stay undefined.
module undo_redo_stack_pair #(
	parameter int MAIN_DEPTH    = urs_pkg::MAIN_DEPTH_DEF,
	parameter int HISTORY_DEPTH = urs_pkg::HISTORY_DEPTH_DEF,
	parameter int ITEM_BITS     = urs_pkg::ITEM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [urs_pkg::S_TDATA_W-1:0] s_tdata,  // item_id
	input  logic [urs_pkg::S_TUSER_W-1:0] s_tuser,  // req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [urs_pkg::M_TDATA_W-1:0] m_tdata   // item_out, status, stack_count, history_count
);
	import urs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic [ID_W-1:0]     item_out;
	logic [STATUS_W-1:0] status;
	logic [SCNT_W-1:0]   stack_count;
	logic [HCNT_W-1:0]   history_count;

	// Sequence requests
	urs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stores and counters
	urs_datapath #(
		.MAIN_DEPTH    (MAIN_DEPTH),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.ITEM_BITS     (ITEM_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (s_tuser[REQ_W-1:0]),
		.item_id       (s_tdata[ID_W-1:0]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.item_out      (item_out),
		.status        (status),
		.stack_count   (stack_count),
		.history_count (history_count)
	);

	// Pack the result fields
	assign m_tdata = M_TDATA_W'({history_count, stack_count, status, item_out});

endmodule

[tb/sv/tb_undo_redo_stack_pair.sv]
// Self-checking testbench for the undo/redo stack pair on its item streams.
module tb_undo_redo_stack_pair;
	import urs_pkg::*;

	localparam int MAIN_D      = MAIN_DEPTH_DEF;
	localparam int HIST_D      = HISTORY_DEPTH_DEF;
	localparam int MAIN_AW     = $clog2(MAIN_D);
	localparam int HIST_AW     = $clog2(HIST_D);
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 307;
	localparam int MAX_PRINTS  = 40;

	// Selector value that carries no request
	localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

	// Request mixes used by the random bursts
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_REPLAY,
		MIX_EVEN
	} traffic_mix_t;

	typedef struct packed {
		logic [4:0]          pad;
		logic [HCNT_W-1:0]   hist_count;
		logic [SCNT_W-1:0]   stack_count;
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     item;
	} stack_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // item_id
	logic [S_TUSER_W-1:0] s_tuser  = '0;  // req_type
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // item_out, status, stack_count, history_count, pad

	// Mirror of the stacks
	logic [ID_W-1:0] main_mirror [MAIN_D];
	logic [ID_W-1:0] hist_mirror [HIST_D];
	int              main_fill;
	int              hist_base;
	int              hist_fill;

	stack_result_t   expected_results [$];
	stack_result_t   got_r;
	stack_result_t   want_r;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int err_count = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_full = 0;
	int n_main_empty = 0;
	int n_hist_empty = 0;
	int n_hist_drop = 0;
	int n_ignored = 0;

	undo_redo_stack_pair u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predict the result of one request and advance the mirror
	function automatic stack_result_t predict_result(logic [REQ_W-1:0] req, logic [ID_W-1:0] id);
		stack_result_t r;
		int slot;
		r = '0;
		r.status = ST_OK;
		case (req)
			REQ_PUSH: begin
				if (main_fill >= MAIN_D) begin
					r.status = ST_MAIN_FULL;
					n_full++;
				end else begin
					main_mirror[main_fill[MAIN_AW-1:0]] = id;
					main_fill++;
				end
			end
			REQ_UNDO: begin
				if (main_fill == 0) begin
					r.status = ST_MAIN_EMPTY;
					n_main_empty++;
				end else begin
					main_fill--;
					r.item = main_mirror[main_fill[MAIN_AW-1:0]];
					// drop the oldest undone item when the history is full
					if (hist_fill >= HIST_D) begin
						hist_base = (hist_base + 1) % HIST_D;
						hist_fill = HIST_D - 1;
						n_hist_drop++;
					end
					slot = (hist_base + hist_fill) % HIST_D;
					hist_mirror[slot[HIST_AW-1:0]] = r.item;
					hist_fill++;
				end
			end
			REQ_REDO: begin
				if (hist_fill == 0) begin
					r.status = ST_HIST_EMPTY;
					n_hist_empty++;
				end else if (main_fill >= MAIN_D) begin
					// keep the history entry on a full stack
					r.status = ST_MAIN_FULL;
					n_full++;
				end else begin
					hist_fill--;
					slot = (hist_base + hist_fill) % HIST_D;
					r.item = hist_mirror[slot[HIST_AW-1:0]];
					main_mirror[main_fill[MAIN_AW-1:0]] = r.item;
					main_fill++;
				end
			end
			default: begin
				n_ignored++;
			end
		endcase
		r.stack_count = main_fill[SCNT_W-1:0];
		r.hist_count = hist_fill[HCNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		if (err_count < MAX_PRINTS)
			$display("MISMATCH %s: expected 0x%0h, got 0x%0h (result %0d)", what, want, got,
				n_checked);
		err_count++;
	endtask

	// Offer one item, hold it until accepted, then queue its prediction
	task automatic send_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= id;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(predict_result(req, id));
		n_sent++;
	endtask

	// Randomize receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_r = m_tdata[$bits(stack_result_t)-1:0];
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 0, m_tdata);
			end else begin
				want_r = expected_results.pop_front();
				if (got_r.item !== want_r.item)
					report_mismatch("item_out", 32'(want_r.item), 32'(got_r.item));
				if (got_r.status !== want_r.status)
					report_mismatch("status", 32'(want_r.status), 32'(got_r.status));
				if (got_r.stack_count !== want_r.stack_count)
					report_mismatch("stack_count", 32'(want_r.stack_count),
						32'(got_r.stack_count));
				if (got_r.hist_count !== want_r.hist_count)
					report_mismatch("history_count", 32'(want_r.hist_count),
						32'(got_r.hist_count));
				if (m_tdata[M_TDATA_W-1:$bits(stack_result_t)-5] !== '0)
					report_mismatch("tdata pad", 0,
						32'(m_tdata[M_TDATA_W-1:$bits(stack_result_t)-5]));
			end
			n_checked++;
		end
	end

	// End the run when no item moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Undo and redo with nothing stored, and the unused selector
	task automatic test_empty_requests();
		send_request(REQ_UNDO, 16'hFFFF);
		send_request(REQ_REDO, 16'h0000);
		send_request(REQ_IGNORED, 16'hFFFF);
	endtask

	// Extreme identifiers through a push, undo and redo round trip
	task automatic test_id_extremes();
		send_request(REQ_PUSH, 16'h0000);
		send_request(REQ_PUSH, 16'hFFFF);
		send_request(REQ_PUSH, 16'h8000);
		send_request(REQ_PUSH, 16'h0001);
		send_request(REQ_IGNORED, 16'h1234);
		send_request(REQ_UNDO, 16'h0000);
		send_request(REQ_UNDO, 16'hFFFF);
		send_request(REQ_REDO, 16'h5555);
		send_request(REQ_REDO, 16'hAAAA);
	endtask

	// History order, push with history held, and undo down to empty
	task automatic test_history_order();
		send_request(REQ_UNDO, 16'h0000);
		send_request(REQ_PUSH, 16'hA5A5);
		send_request(REQ_UNDO, 16'h0000);
		send_request(REQ_UNDO, 16'h0000);
		send_request(REQ_UNDO, 16'h0000);
		send_request(REQ_UNDO, 16'h0000);
		send_request(REQ_UNDO, 16'h0000);
		send_request(REQ_REDO, 16'h0000);
		send_request(REQ_REDO, 16'h0000);
		send_request(REQ_REDO, 16'h0000);
	endtask

	// Random bursts, each leaning toward filling, draining or replaying, or evenly mixed
	task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
		int left;
		int burst;
		int pick;
		int w_push;
		int w_undo;
		int w_redo;
		traffic_mix_t mix;
		logic [REQ_W-1:0] req;
		left = n_items;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (left > 0) begin
			burst = $urandom_range(40, 6);
			mix = traffic_mix_t'($urandom_range(3));
			case (mix)
				MIX_FILL:   begin w_push = 70; w_undo = 10; w_redo = 16; end
				MIX_DRAIN:  begin w_push = 10; w_undo = 75; w_redo = 11; end
				MIX_REPLAY: begin w_push = 15; w_undo = 25; w_redo = 56; end
				default:    begin w_push = 32; w_undo = 32; w_redo = 32; end
			endcase
			while (burst > 0 && left > 0) begin
				pick = $urandom_range(99);
				if (pick < w_push)
					req = REQ_PUSH;
				else if (pick < w_push + w_undo)
					req = REQ_UNDO;
				else if (pick < w_push + w_undo + w_redo)
					req = REQ_REDO;
				else
					req = REQ_IGNORED;
				send_request(req, ID_W'($urandom_range(16'hFFFF)));
				burst--;
				left--;
			end
		end
	endtask

	initial begin
		main_fill = 0;
		hist_base = 0;
		hist_fill = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_requests();
		test_id_extremes();
		test_history_order();
		test_random_traffic(0, 0, PHASE_ITEMS);
		test_random_traffic(77, 0, PHASE_ITEMS);
		test_random_traffic(0, 77, PHASE_ITEMS);
		test_random_traffic(22, 22, PHASE_ITEMS);

		// Drain the remaining results, then allow for stray ones
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests over four back-pressure phases, checked %0d results",
			n_sent, n_checked);
		$display("Seen: %0d full rejects, %0d empty undos, %0d empty redos,",
			n_full, n_main_empty, n_hist_empty);
		$display("      %0d history drops, %0d ignored", n_hist_drop, n_ignored);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[files.f]
sv/urs_pkg.sv
sv/urs_ctrl.sv
sv/urs_datapath.sv
sv/undo_redo_stack_pair.sv
tb/sv/tb_undo_redo_stack_pair.sv
